@@ rtl/core/pfba_pkg.sv @@
// Package for the page frame bitmap allocator.
// Holds the request kind codes and the fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package pfba_pkg;

  localparam int FRAME_W   = 14;
  localparam int KIND_W    = 2;
  localparam int WORD_BITS = 64;
  localparam int BIT_AW    = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_MARK  = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_ALLOC = 2'd3
  } kind_t;

endpackage

@@ rtl/core/pfba_in_if.sv @@
// Request channel of the page frame bitmap allocator: valid/ready and payload.
// Depends on pfba_pkg for field widths.
`timescale 1ns / 1ps

interface pfba_in_if;
  logic                         valid;
  logic                         ready;
  logic [pfba_pkg::KIND_W-1:0]  kind;
  logic [pfba_pkg::FRAME_W-1:0] frame;

  modport source (output valid, output kind, output frame, input ready);
  modport sink   (input valid, input kind, input frame, output ready);
endinterface

@@ rtl/core/pfba_out_if.sv @@
// Result channel of the page frame bitmap allocator: valid/ready and payload.
// Depends on pfba_pkg for field widths.
`timescale 1ns / 1ps

interface pfba_out_if;
  logic                         valid;
  logic                         ready;
  logic [pfba_pkg::FRAME_W-1:0] result_frame;
  logic                         was_used;
  logic                         ok;

  modport source (output valid, output result_frame, output was_used, output ok, input ready);
  modport sink   (input valid, input result_frame, input was_used, input ok, output ready);
endinterface

@@ rtl/core/pfba_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pfba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/page_frame_bitmap_allocator_unit.sv @@
// Page frame bitmap allocator: one used bit per frame in a word memory, a full-word
// summary memory above it and a row of top-level full flags in registers.
// Mark, free and query read the word and summary on acceptance, then finish in the commit
// state; allocate scans the top flags, then reads the summary word and then the word. One item at a time.
// Reset: an init sweep over every word address writes the reserved pattern into both
// memories; no item is accepted until it finishes.
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_unit #(
  parameter int NUM_FRAMES      = 16384,
  parameter int RESERVED_FRAMES = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  pfba_in_if.sink     in_ch,
  pfba_out_if.source  out_ch
);

  localparam int WORD_COUNT = (NUM_FRAMES + 63) / 64;
  localparam int SUM_COUNT  = (WORD_COUNT + 63) / 64;
  localparam int TOP_COUNT  = (SUM_COUNT + 63) / 64;
  localparam int WORD_AW    = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
  localparam int SUM_AW     = SUM_COUNT > 1 ? $clog2(SUM_COUNT) : 1;
  localparam int TOP_AW     = TOP_COUNT > 1 ? $clog2(TOP_COUNT) : 1;
  localparam int SX         = TOP_AW + pfba_pkg::BIT_AW;
  localparam int WX         = SX + pfba_pkg::BIT_AW;
  localparam int FX         = WX + pfba_pkg::BIT_AW;
  localparam int INIT_W     = $clog2(WORD_COUNT + 1);
  localparam int RES_C      = RESERVED_FRAMES > NUM_FRAMES ? NUM_FRAMES : RESERVED_FRAMES;
  localparam int WB         = pfba_pkg::WORD_BITS;

  typedef logic [WB-1:0] word_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_TOP,
    ST_SUM,
    ST_COMMIT
  } state_t;

  // bits past the last frame in the last word count as used for the search
  function automatic word_t last_pad();
    word_t r;
    for (int j = 0; j < WB; j++) begin
      r[j] = ((WORD_COUNT - 1) * WB + j) >= NUM_FRAMES;
    end
    return r;
  endfunction

  function automatic word_t word_rst(int w);
    word_t r;
    for (int j = 0; j < WB; j++) begin
      r[j] = (w * WB + j) < RES_C;
    end
    return r;
  endfunction

  function automatic word_t sum_rst(int s);
    word_t r;
    int    wi;
    for (int j = 0; j < WB; j++) begin
      wi   = s * WB + j;
      r[j] = (wi >= WORD_COUNT) || ((wi + 1) * WB <= RES_C) || (RES_C == NUM_FRAMES);
    end
    return r;
  endfunction

  function automatic word_t top_rst(int t);
    word_t r;
    int    si;
    for (int j = 0; j < WB; j++) begin
      si   = t * WB + j;
      r[j] = (si >= SUM_COUNT) || ((si + 1) * WB * WB <= RES_C) || (RES_C == NUM_FRAMES);
    end
    return r;
  endfunction

  // {found, index} of the lowest clear bit
  function automatic logic [pfba_pkg::BIT_AW:0] first_zero(word_t v);
    logic [pfba_pkg::BIT_AW:0] r;
    r = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (!v[i]) begin
        r = {1'b1, pfba_pkg::BIT_AW'(i)};
      end
    end
    return r;
  endfunction

  localparam word_t LAST_PAD = last_pad();

  state_t                       state_r;
  logic [INIT_W-1:0]            init_cnt_r;
  word_t                        top_r [TOP_COUNT];
  logic [TOP_AW-1:0]            tcnt_r;
  logic [SX-1:0]                sidx_r;
  logic [WX-1:0]                widx_r;
  logic [pfba_pkg::BIT_AW-1:0]  bit_r;
  pfba_pkg::kind_t              op_r;
  logic                         out_valid_r;
  logic [pfba_pkg::FRAME_W-1:0] out_frame_r;
  logic                         out_was_r;
  logic                         out_ok_r;

  logic                  we0, re0, we1, re1;
  logic [WORD_AW-1:0]    waddr0, raddr0;
  logic [SUM_AW-1:0]     waddr1, raddr1;
  word_t                 wdata0, rdata0, wdata1, rdata1;

  logic                         in_fire;
  pfba_pkg::kind_t              in_kind;
  logic                         in_frame_ok;
  logic [FX-1:0]                in_fx;
  logic [WX-1:0]                in_widx;
  logic [SX-1:0]                in_sidx;
  word_t                        top_word;
  logic [pfba_pkg::BIT_AW:0]    top_fz;
  logic [SX-1:0]                s_sel;
  logic [pfba_pkg::BIT_AW:0]    sum_fz;
  logic [WX-1:0]                w_sel;
  word_t                        pad;
  logic [pfba_pkg::BIT_AW:0]    word_fz;
  logic [pfba_pkg::BIT_AW-1:0]  c_bit;
  logic                         c_was;
  word_t                        new_word;
  logic                         word_full;
  logic [SX-1:0]                c_sidx;
  word_t                        new_sum;
  logic                         sum_full;
  logic                         c_write;
  logic [FX-1:0]                c_frame;
  logic                         out_load;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_kind     = pfba_pkg::kind_t'(in_ch.kind);
  assign in_frame_ok = 32'(in_ch.frame) < 32'(NUM_FRAMES);
  assign in_fx       = FX'(in_ch.frame);
  assign in_widx     = in_fx[FX-1:pfba_pkg::BIT_AW];
  assign in_sidx     = in_widx[WX-1:pfba_pkg::BIT_AW];

  // allocate search: top flags, then summary word, then bitmap word
  assign top_word = top_r[tcnt_r];
  assign top_fz   = first_zero(top_word);
  assign s_sel    = {tcnt_r, top_fz[pfba_pkg::BIT_AW-1:0]};
  assign sum_fz   = first_zero(rdata1);
  assign w_sel    = {sidx_r, sum_fz[pfba_pkg::BIT_AW-1:0]};

  // commit: modify the word and propagate its full flag upward
  assign pad     = (widx_r == WX'(WORD_COUNT - 1)) ? LAST_PAD : '0;
  assign word_fz = first_zero(rdata0 | pad);
  assign c_bit   = (op_r == pfba_pkg::KIND_ALLOC) ? word_fz[pfba_pkg::BIT_AW-1:0] : bit_r;
  assign c_was   = rdata0[c_bit];
  assign c_write = (op_r != pfba_pkg::KIND_QUERY);
  assign c_sidx  = widx_r[WX-1:pfba_pkg::BIT_AW];
  assign c_frame = {widx_r, c_bit};

  // a new result is loaded this cycle
  assign out_load = ((state_r == ST_IDLE) && in_fire && !in_frame_ok &&
                     (in_kind != pfba_pkg::KIND_ALLOC)) ||
                    ((state_r == ST_TOP) && !top_fz[pfba_pkg::BIT_AW] &&
                     (tcnt_r == TOP_AW'(TOP_COUNT - 1))) ||
                    (state_r == ST_COMMIT);

  always_comb begin
    new_word = rdata0;
    case (op_r)
      pfba_pkg::KIND_MARK,
      pfba_pkg::KIND_ALLOC: new_word[c_bit] = 1'b1;
      pfba_pkg::KIND_FREE:  new_word[c_bit] = 1'b0;
      default:              new_word = rdata0;
    endcase
  end

  assign word_full = &(new_word | pad);

  always_comb begin
    new_sum = rdata1;
    new_sum[widx_r[pfba_pkg::BIT_AW-1:0]] = word_full;
  end

  assign sum_full = &new_sum;

  // memory ports
  always_comb begin
    if (state_r == ST_INIT) begin
      we0    = 1'b1;
      waddr0 = init_cnt_r[WORD_AW-1:0];
      wdata0 = word_rst(int'(init_cnt_r));
      we1    = 32'(init_cnt_r) < 32'(SUM_COUNT);
      waddr1 = init_cnt_r[SUM_AW-1:0];
      wdata1 = sum_rst(int'(init_cnt_r));
    end else begin
      we0    = (state_r == ST_COMMIT) && c_write;
      waddr0 = widx_r[WORD_AW-1:0];
      wdata0 = new_word;
      we1    = (state_r == ST_COMMIT) && c_write;
      waddr1 = c_sidx[SUM_AW-1:0];
      wdata1 = new_sum;
    end
  end

  always_comb begin
    if (state_r == ST_IDLE) begin
      re0    = in_fire && in_frame_ok && (in_kind != pfba_pkg::KIND_ALLOC);
      raddr0 = in_widx[WORD_AW-1:0];
      re1    = re0;
      raddr1 = in_sidx[SUM_AW-1:0];
    end else begin
      re0    = (state_r == ST_SUM);
      raddr0 = w_sel[WORD_AW-1:0];
      re1    = (state_r == ST_TOP) && top_fz[pfba_pkg::BIT_AW];
      raddr1 = s_sel[SUM_AW-1:0];
    end
  end

  pfba_ram #(.WIDTH(WB), .DEPTH(WORD_COUNT)) u_word_ram (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .re    (re0),
    .raddr (raddr0),
    .rdata (rdata0)
  );

  pfba_ram #(.WIDTH(WB), .DEPTH(SUM_COUNT)) u_sum_ram (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (wdata1),
    .re    (re1),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      tcnt_r      <= '0;
      for (int t = 0; t < TOP_COUNT; t++) begin
        top_r[t] <= top_rst(t);
      end
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_INIT: begin
          init_cnt_r <= init_cnt_r + 1'b1;
          if (init_cnt_r == INIT_W'(WORD_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            op_r <= in_kind;
            if (!in_frame_ok && (in_kind != pfba_pkg::KIND_ALLOC)) begin
              // out of range frame: echo it, change nothing
              out_valid_r <= 1'b1;
              out_frame_r <= in_ch.frame;
              out_was_r   <= 1'b0;
              out_ok_r    <= 1'b0;
            end else if (in_kind == pfba_pkg::KIND_ALLOC) begin
              tcnt_r  <= '0;
              state_r <= ST_TOP;
            end else begin
              widx_r  <= in_widx;
              bit_r   <= in_fx[pfba_pkg::BIT_AW-1:0];
              state_r <= ST_COMMIT;
            end
          end
        end
        ST_TOP: begin
          if (top_fz[pfba_pkg::BIT_AW]) begin
            sidx_r  <= s_sel;
            state_r <= ST_SUM;
          end else if (tcnt_r == TOP_AW'(TOP_COUNT - 1)) begin
            // every frame used: report failure
            out_valid_r <= 1'b1;
            out_frame_r <= '0;
            out_was_r   <= 1'b0;
            out_ok_r    <= 1'b0;
            state_r     <= ST_IDLE;
          end else begin
            tcnt_r <= tcnt_r + 1'b1;
          end
        end
        ST_SUM: begin
          widx_r  <= w_sel;
          state_r <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (c_write) begin
            top_r[c_sidx[SX-1:pfba_pkg::BIT_AW]][c_sidx[pfba_pkg::BIT_AW-1:0]] <= sum_full;
          end
          out_valid_r <= 1'b1;
          out_frame_r <= c_frame[pfba_pkg::FRAME_W-1:0];
          out_was_r   <= c_was;
          out_ok_r    <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_frame = out_frame_r;
  assign out_ch.was_used     = out_was_r;
  assign out_ch.ok           = out_ok_r;

endmodule
